FILE: hdl/message_mailbox_queue_assert.svh
// ----------------------------------------------------------------------------
// message_mailbox_queue assertion macros
// Concurrent assertion helpers shared by the mailbox queue modules. They
// compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_MAILBOX_QUEUE_ASSERT_SVH
`define MESSAGE_MAILBOX_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MMQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mailbox queue assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define MMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mailbox queue assertion failed");
`else
`define MMQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/mmq_pkg.sv
// ----------------------------------------------------------------------------
// mmq_pkg
// Types, widths and codes shared by the message mailbox queue.
// ----------------------------------------------------------------------------
package mmq_pkg;

  // Default sizes of the ring and of one payload.
  localparam int QUEUE_SLOTS_DEF   = 8;
  localparam int PAYLOAD_BYTES_DEF = 8;

  // Fixed field widths.
  localparam int LEN_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int PAY_W    = 64;
  localparam int STATUS_W = 3;

  // Depth of the command queue between front and back.
  localparam int CMDQ_DEPTH = 2;

  // Input opcode values.
  localparam logic OPC_SEND = 1'b0;
  localparam logic OPC_RECV = 1'b1;

  // Result status codes.
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_SENT       = 3'd0;
  localparam status_t ST_FULL       = 3'd1;
  localparam status_t ST_RECEIVED   = 3'd2;
  localparam status_t ST_EMPTY      = 3'd3;
  localparam status_t ST_TOO_SMALL  = 3'd4;
  localparam status_t ST_BAD_LENGTH = 3'd5;

  // Classified command kinds.
  typedef logic [1:0] cmd_op_t;
  localparam cmd_op_t CMD_SEND = 2'd0;
  localparam cmd_op_t CMD_RECV = 2'd1;
  localparam cmd_op_t CMD_BAD  = 2'd2;

  // One classified command as it travels from front to back.
  typedef struct packed {
    cmd_op_t            op;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  kind;
    logic [PAY_W-1:0]   payload;
    logic [BYTE_W-1:0]  max_len;
  } cmd_t;

endpackage

FILE: hdl/mmq_if.sv
// ----------------------------------------------------------------------------
// mmq_if
// Valid/ready channels of the mailbox queue: request and result.
// ----------------------------------------------------------------------------
interface mmq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [mmq_pkg::BYTE_W-1:0]   msg_length;
  logic [mmq_pkg::BYTE_W-1:0]   msg_kind;
  logic [mmq_pkg::PAY_W-1:0]    payload_in;
  logic [mmq_pkg::BYTE_W-1:0]   max_length;

  modport source (output valid, opcode, msg_length, msg_kind, payload_in, max_length,
                  input ready);
  modport sink   (input valid, opcode, msg_length, msg_kind, payload_in, max_length,
                  output ready);
endinterface

interface mmq_out_if;
  logic                         valid;
  logic                         ready;
  logic [mmq_pkg::STATUS_W-1:0] status;
  logic [mmq_pkg::LEN_W-1:0]    length_out;
  logic [mmq_pkg::BYTE_W-1:0]   kind_out;
  logic [mmq_pkg::PAY_W-1:0]    payload_out;
  logic                         message_waiting;

  modport source (output valid, status, length_out, kind_out, payload_out, message_waiting,
                  input ready);
  modport sink   (input valid, status, length_out, kind_out, payload_out, message_waiting,
                  output ready);
endinterface

FILE: hdl/mmq_ram.sv
// ----------------------------------------------------------------------------
// mmq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/mmq_front.sv
// ----------------------------------------------------------------------------
// mmq_front
// Accepts requests, classifies them, trims the payload to its length and
// holds them in a short command queue for the back end.
// ----------------------------------------------------------------------------
`include "message_mailbox_queue_assert.svh"

module mmq_front #(
  parameter int PAYLOAD_BYTES = mmq_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  mmq_in_if.sink        in_if,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output mmq_pkg::cmd_t cmd
);

  localparam int DEPTH = mmq_pkg::CMDQ_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mmq_pkg::cmd_t      cls;
  mmq_pkg::cmd_t      q_r [DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  // Classification and payload trimming.
  always_comb begin
    cls         = '0;
    cls.kind    = in_if.msg_kind;
    cls.max_len = in_if.max_length;
    cls.len     = in_if.msg_length[mmq_pkg::LEN_W-1:0];
    if (in_if.opcode == mmq_pkg::OPC_RECV) begin
      cls.op = mmq_pkg::CMD_RECV;
    end else if (in_if.msg_length > mmq_pkg::BYTE_W'(PAYLOAD_BYTES)) begin
      cls.op = mmq_pkg::CMD_BAD;
    end else begin
      cls.op = mmq_pkg::CMD_SEND;
    end
    for (int i = 0; i < mmq_pkg::PAY_W / mmq_pkg::BYTE_W; i++) begin
      if (i < PAYLOAD_BYTES && mmq_pkg::BYTE_W'(i) < in_if.msg_length) begin
        cls.payload[i*mmq_pkg::BYTE_W +: mmq_pkg::BYTE_W] =
          in_if.payload_in[i*mmq_pkg::BYTE_W +: mmq_pkg::BYTE_W];
      end
    end
  end

  assign in_if.ready = (cnt_r != CNT_W'(DEPTH));
  assign push        = in_if.valid && in_if.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cls;
    end
  end

  // The queue never holds more entries than it has.
  `MMQ_ASSERT_IMPLIES(a_cmdq_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH))

endmodule

FILE: hdl/mmq_back.sv
// ----------------------------------------------------------------------------
// mmq_back
// Executes classified commands against the slot ring and registers results.
// ----------------------------------------------------------------------------
`include "message_mailbox_queue_assert.svh"

module mmq_back #(
  parameter int QUEUE_SLOTS   = mmq_pkg::QUEUE_SLOTS_DEF,
  parameter int PAYLOAD_BYTES = mmq_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  mmq_pkg::cmd_t cmd,
  mmq_out_if.source     out_if
);

  localparam int IDX_W   = $clog2(QUEUE_SLOTS);
  localparam int SPAY_W  = mmq_pkg::BYTE_W * PAYLOAD_BYTES;
  localparam int ENTRY_W = mmq_pkg::LEN_W + mmq_pkg::BYTE_W + SPAY_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                          state_r, state_nxt;
  logic [IDX_W-1:0]              wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]              rd_idx_r, rd_idx_nxt;
  logic [QUEUE_SLOTS-1:0]        full_r, full_nxt;
  logic [mmq_pkg::BYTE_W-1:0]    max_len_r, max_len_nxt;

  logic                          out_valid_r, out_valid_nxt;
  mmq_pkg::status_t              status_r, status_nxt;
  logic [mmq_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [mmq_pkg::BYTE_W-1:0]    kind_r, kind_nxt;
  logic [mmq_pkg::PAY_W-1:0]     pay_r, pay_nxt;
  logic                          wait_r, wait_nxt;

  logic                          out_free, cmd_pop, load;
  logic                          ram_we, ram_re;
  logic [ENTRY_W-1:0]            ram_wdata, ram_rdata;
  logic [mmq_pkg::LEN_W-1:0]     rd_len;
  logic [mmq_pkg::BYTE_W-1:0]    rd_kind;
  logic [SPAY_W-1:0]             rd_pay;

  assign out_free  = !out_valid_r || out_if.ready;
  assign cmd_ready = (state_r == S_IDLE) && out_free;
  assign cmd_pop   = cmd_valid && cmd_ready;

  assign ram_wdata = {cmd.len, cmd.kind, cmd.payload[SPAY_W-1:0]};
  assign {rd_len, rd_kind, rd_pay} = ram_rdata;

  mmq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    full_nxt    = full_r;
    max_len_nxt = max_len_r;
    load        = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    status_nxt  = mmq_pkg::ST_SENT;
    len_nxt     = '0;
    kind_nxt    = '0;
    pay_nxt     = '0;

    if (cmd_pop) begin
      unique case (cmd.op)
        mmq_pkg::CMD_BAD: begin
          load       = 1'b1;
          status_nxt = mmq_pkg::ST_BAD_LENGTH;
        end
        mmq_pkg::CMD_SEND: begin
          load = 1'b1;
          if (full_r[wr_idx_r]) begin
            status_nxt = mmq_pkg::ST_FULL;
          end else begin
            ram_we             = 1'b1;
            full_nxt[wr_idx_r] = 1'b1;
            wr_idx_nxt = (wr_idx_r == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : wr_idx_r + 1'b1;
            status_nxt = mmq_pkg::ST_SENT;
          end
        end
        mmq_pkg::CMD_RECV: begin
          if (!full_r[rd_idx_r]) begin
            load       = 1'b1;
            status_nxt = mmq_pkg::ST_EMPTY;
          end else begin
            ram_re      = 1'b1;
            max_len_nxt = cmd.max_len;
            state_nxt   = S_READ;
          end
        end
        default: begin
          load       = 1'b1;
          status_nxt = mmq_pkg::ST_BAD_LENGTH;
        end
      endcase
    end else if (state_r == S_READ && out_free) begin
      state_nxt = S_IDLE;
      load      = 1'b1;
      if (mmq_pkg::BYTE_W'(rd_len) > max_len_r) begin
        status_nxt = mmq_pkg::ST_TOO_SMALL;
      end else begin
        status_nxt         = mmq_pkg::ST_RECEIVED;
        len_nxt            = rd_len;
        kind_nxt           = rd_kind;
        pay_nxt            = mmq_pkg::PAY_W'(rd_pay);
        full_nxt[rd_idx_r] = 1'b0;
        rd_idx_nxt = (rd_idx_r == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : rd_idx_r + 1'b1;
      end
    end

    wait_nxt = full_nxt[rd_idx_nxt];

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    max_len_r <= max_len_nxt;
    if (load) begin
      status_r <= status_nxt;
      len_r    <= len_nxt;
      kind_r   <= kind_nxt;
      pay_r    <= pay_nxt;
      wait_r   <= wait_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.status          = status_r;
  assign out_if.length_out      = len_r;
  assign out_if.kind_out        = kind_r;
  assign out_if.payload_out     = pay_r;
  assign out_if.message_waiting = wait_r;

  // No new command is taken while a slot read is outstanding.
  `MMQ_ASSERT_IMPLIES(a_read_blocks_pop, clk, rst_n, state_r == S_READ, !cmd_pop)
  // A delivered message never claims more bytes than a slot holds.
  `MMQ_ASSERT_IMPLIES(a_rx_len_fits, clk, rst_n, load && status_nxt == mmq_pkg::ST_RECEIVED, mmq_pkg::BYTE_W'(len_nxt) <= mmq_pkg::BYTE_W'(PAYLOAD_BYTES))
  // A successful send leaves at least one slot marked full.
  `MMQ_ASSERT_NEXT(a_send_sets_full, clk, rst_n, load && status_nxt == mmq_pkg::ST_SENT, full_r != '0)

endmodule

FILE: hdl/message_mailbox_queue.sv
// ----------------------------------------------------------------------------
// message_mailbox_queue
// Ring of message slots with full flags; send and receive requests in,
// one status result out per request.
// ----------------------------------------------------------------------------
// The mailbox takes one request per transfer on in_if and returns exactly one
// result per request on out_if, in request order. A send that the back end
// accepts writes its slot and loads the result register at once, so
// back-to-back sends sustain one per cycle while out_if takes each result; a
// receive that finds a message holds off the next command while the slot
// contents come out of a RAM with a registered read. A request that finds
// the write slot still full, the read slot empty or a receiver too small
// leaves the ring unchanged. A two-entry command queue sits between the
// request front end and the back end, so requests keep flowing in while a
// result waits in the output register. No RAM clearing pass is needed after
// reset: slot data is read only from a slot whose flag a send has set.
// ----------------------------------------------------------------------------
module message_mailbox_queue #(
  parameter int QUEUE_SLOTS   = mmq_pkg::QUEUE_SLOTS_DEF,
  parameter int PAYLOAD_BYTES = mmq_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mmq_in_if.sink    in_if,
  mmq_out_if.source out_if
);

  // Classified command handed from the front end to the back end.
  logic          cmd_valid;
  logic          cmd_ready;
  mmq_pkg::cmd_t cmd;

  // The front end checks the send length, trims the payload to that length
  // and queues the command.
  mmq_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // The back end owns the ring indices, the full flags and the slot RAM,
  // and registers each result until the downstream side takes it.
  mmq_back #(
    .QUEUE_SLOTS   (QUEUE_SLOTS),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_if    (out_if)
  );

endmodule
